// ----- rtl/core/dtip_pkg.sv -----
// Shared types and constants for the dual timer and interrupt port block.
// Depends on nothing; used by the timer stage, the top level and the checker.
package dtip_pkg;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_RAISE = 2'd3
    } action_t;

    localparam logic [3:0] ADDR_PORT_A  = 4'd0;
    localparam logic [3:0] ADDR_PORT_B  = 4'd1;
    localparam logic [3:0] ADDR_DIR_A   = 4'd2;
    localparam logic [3:0] ADDR_DIR_B   = 4'd3;
    localparam logic [3:0] ADDR_TA_LO   = 4'd4;
    localparam logic [3:0] ADDR_TA_HI   = 4'd5;
    localparam logic [3:0] ADDR_TB_LO   = 4'd6;
    localparam logic [3:0] ADDR_TB_HI   = 4'd7;
    localparam logic [3:0] ADDR_SERIAL  = 4'd12;
    localparam logic [3:0] ADDR_INT     = 4'd13;
    localparam logic [3:0] ADDR_CTRL_A  = 4'd14;
    localparam logic [3:0] ADDR_CTRL_B  = 4'd15;

    typedef enum logic [2:0] {
        PH_STOP            = 3'd0,
        PH_WAIT_COUNT      = 3'd1,
        PH_LOAD_STOP       = 3'd2,
        PH_LOAD_COUNT      = 3'd3,
        PH_LOAD_WAIT_COUNT = 3'd4,
        PH_COUNT_STOP      = 3'd5,
        PH_COUNT           = 3'd6
    } phase_t;

    typedef struct packed {
        logic [15:0] cnt;
        logic [15:0] reload;
        logic [7:0]  ctrl;
        logic [8:0]  staged;   // bit 8: byte pending
        phase_t      phase;
    } timer_t;

    typedef struct packed {
        logic [7:0] port_a;
        logic [7:0] port_b;
        logic [7:0] dir_a;
        logic [7:0] dir_b;
        logic [7:0] serial;
        logic [7:0] flags;
        logic [6:0] enable;
        timer_t     ta;
        timer_t     tb;
        logic [2:0] count_source;
    } unit_state_t;

    localparam timer_t TIMER_RESET_C = '{
        cnt: 16'hffff, reload: 16'h0001, ctrl: 8'h00, staged: 9'h000, phase: PH_STOP};

    localparam unit_state_t UNIT_RESET_C = '{
        port_a: 8'h00, port_b: 8'h00, dir_a: 8'h00, dir_b: 8'h00, serial: 8'h00,
        flags: 8'h00, enable: 7'h00, ta: TIMER_RESET_C, tb: TIMER_RESET_C,
        count_source: 3'b000};

endpackage

// ----- rtl/core/dtip_timer.sv -----
// One tick of a 16-bit down counter with reload, modes and staged control.
// Depends on dtip_pkg.
module dtip_timer (
    input  dtip_pkg::timer_t cur,
    input  logic             tick_in,
    output dtip_pkg::timer_t nxt,
    output logic             under,
    output logic             raise
);

    logic       force_ld;
    logic       counting;
    logic       zero;
    logic [15:0] dec;
    logic [7:0] nv;

    always_comb begin
        nxt      = cur;
        force_ld = 1'b0;
        counting = 1'b0;
        under    = 1'b0;
        raise    = 1'b0;
        zero     = 1'b0;
        dec      = cur.cnt - 16'd1;
        nv       = cur.staged[7:0];

        case (cur.phase)
            dtip_pkg::PH_WAIT_COUNT: begin
                nxt.phase = dtip_pkg::PH_COUNT;
            end
            dtip_pkg::PH_LOAD_STOP: begin
                nxt.phase = dtip_pkg::PH_STOP;
                nxt.cnt   = cur.reload;
            end
            dtip_pkg::PH_LOAD_COUNT: begin
                nxt.phase = dtip_pkg::PH_COUNT;
                nxt.cnt   = cur.reload;
            end
            dtip_pkg::PH_LOAD_WAIT_COUNT: begin
                nxt.phase = dtip_pkg::PH_WAIT_COUNT;
                if (cur.cnt == 16'd1) begin
                    force_ld = 1'b1;
                    counting = 1'b1;
                end else begin
                    nxt.cnt = cur.reload;
                end
            end
            dtip_pkg::PH_COUNT_STOP: begin
                nxt.phase = dtip_pkg::PH_STOP;
                counting  = 1'b1;
            end
            dtip_pkg::PH_COUNT: begin
                counting = 1'b1;
            end
            default: begin
            end
        endcase

        // count down, reload on reaching zero
        if (counting && (tick_in || force_ld)) begin
            zero = (nxt.cnt == 16'd0);
            if (!zero) begin
                dec     = nxt.cnt - 16'd1;
                nxt.cnt = dec;
                zero    = (dec == 16'd0);
            end
            if (zero || force_ld) begin
                if (nxt.phase != dtip_pkg::PH_STOP || force_ld) begin
                    nxt.cnt = cur.reload;
                    raise   = 1'b1;
                    if (nxt.ctrl[3]) begin
                        nxt.ctrl[0]   = 1'b0;
                        nxt.staged[0] = 1'b0;
                        nv[0]         = 1'b0;
                        nxt.phase     = dtip_pkg::PH_LOAD_STOP;
                    end else begin
                        nxt.phase = dtip_pkg::PH_LOAD_COUNT;
                    end
                end
                under = 1'b1;
            end
        end

        // take up a staged control byte
        if (nxt.staged[8]) begin
            case (nxt.phase)
                dtip_pkg::PH_COUNT: begin
                    if (nv[0]) begin
                        if (nv[4]) nxt.phase = dtip_pkg::PH_LOAD_WAIT_COUNT;
                    end else begin
                        nxt.phase = nv[4] ? dtip_pkg::PH_LOAD_STOP : dtip_pkg::PH_COUNT_STOP;
                    end
                end
                dtip_pkg::PH_LOAD_COUNT, dtip_pkg::PH_WAIT_COUNT: begin
                    if (nv[0]) begin
                        if (nv[3]) begin
                            nv[0]     = 1'b0;
                            nxt.phase = dtip_pkg::PH_STOP;
                        end else if (nv[4]) begin
                            nxt.phase = dtip_pkg::PH_LOAD_WAIT_COUNT;
                        end
                    end else begin
                        nxt.phase = dtip_pkg::PH_STOP;
                    end
                end
                dtip_pkg::PH_LOAD_WAIT_COUNT, dtip_pkg::PH_COUNT_STOP: begin
                end
                default: begin
                    if (nv[0]) begin
                        nxt.phase = nv[4] ? dtip_pkg::PH_LOAD_WAIT_COUNT
                                          : dtip_pkg::PH_WAIT_COUNT;
                    end else if (nv[4]) begin
                        nxt.phase = dtip_pkg::PH_LOAD_STOP;
                    end
                end
            endcase
            nxt.ctrl   = nv & 8'hef;
            nxt.staged = 9'h000;
        end
    end

endmodule

// ----- rtl/core/dual_timer_interrupt_port_block_top.sv -----
// Top level of the dual timer and interrupt port block: unit state memory,
// read-modify-write stage and output register. Depends on dtip_pkg, dtip_timer.
//
//   channel   direction  ports                                          transfer when
//   s_        in         s_action s_unit s_address s_write_data         s_valid & s_ready
//                        s_source_bits
//   m_        out        m_read_data m_irq_pending                      m_valid & m_ready
//
// One item per cycle sustained while m_ready does not stall the output; a result
// is held in stage 1 and then in the output register before it can be taken.
// The per-unit state memory (one entry per unit, one read and one write port)
// sets the rate: the read is issued at the input transfer, the modify and write
// back happen in stage 1, with forwarding when consecutive items hit one unit.
// Reset (aresetn low, synchronous) empties the pipe and marks every entry as
// unwritten, so it reads as the reset state. A stall on m_ready holds both stages.
module dual_timer_interrupt_port_block_top #(
    parameter int UNITS = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic       s_unit,
    input  logic [3:0] s_address,
    input  logic [7:0] s_write_data,
    input  logic [4:0] s_source_bits,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_irq_pending
);

    localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;

    dtip_pkg::unit_state_t mem [UNITS];
    logic [UNITS-1:0]      written_reg;

    // stage 1 (state read in flight)
    logic                  s1_valid_reg;
    logic                  s1_ok_reg;
    logic [UW-1:0]         s1_idx_reg;
    logic                  s1_unit_reg;
    logic [1:0]            s1_action_reg;
    logic [3:0]            s1_address_reg;
    logic [7:0]            s1_wdata_reg;
    logic [4:0]            s1_src_reg;
    dtip_pkg::unit_state_t mem_q_reg;
    logic                  mem_ok_reg;
    logic                  fwd_reg;
    dtip_pkg::unit_state_t wb_data_reg;

    logic                  m_valid_reg;
    logic [7:0]            m_read_data_reg;
    logic                  m_irq_reg;

    logic                  advance;
    logic                  accept;
    logic                  wr_en;
    logic [UW-1:0]         in_idx;
    logic                  in_ok;
    dtip_pkg::unit_state_t cur;
    dtip_pkg::unit_state_t nxt;
    logic [7:0]            rd_val;
    dtip_pkg::timer_t      ta_next;
    dtip_pkg::timer_t      tb_next;
    logic                  ta_under;
    logic                  tb_under;
    logic                  ta_raise;
    logic                  tb_raise;
    logic                  tb_tick;
    logic [6:0]            new_enable;

    // advance whenever the output register is free or being drained
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;
    assign wr_en   = advance && s1_valid_reg && s1_ok_reg;
    assign in_idx  = UW'(s_unit);
    assign in_ok   = (32'(s_unit) < UNITS);

    // forwarded write wins over stale memory, unwritten entries read as reset
    assign cur = fwd_reg ? wb_data_reg : (mem_ok_reg ? mem_q_reg : dtip_pkg::UNIT_RESET_C);

    assign tb_tick = cur.count_source[1] || (cur.count_source[2] && ta_under);

    dtip_timer u_timer_a (
        .cur     (cur.ta),
        .tick_in (cur.count_source[0]),
        .nxt     (ta_next),
        .under   (ta_under),
        .raise   (ta_raise)
    );

    dtip_timer u_timer_b (
        .cur     (cur.tb),
        .tick_in (tb_tick),
        .nxt     (tb_next),
        .under   (tb_under),
        .raise   (tb_raise)
    );

    always_comb begin
        nxt        = cur;
        rd_val     = 8'h00;
        new_enable = cur.enable;
        case (s1_action_reg)
            dtip_pkg::ACT_READ: begin
                case (s1_address_reg)
                    dtip_pkg::ADDR_PORT_A: begin
                        rd_val = cur.port_a | ~cur.dir_a;
                        if (s1_unit_reg) rd_val = rd_val & 8'h3f;
                    end
                    dtip_pkg::ADDR_PORT_B: rd_val = cur.port_b | ~cur.dir_b;
                    dtip_pkg::ADDR_DIR_A:  rd_val = cur.dir_a;
                    dtip_pkg::ADDR_DIR_B:  rd_val = cur.dir_b;
                    dtip_pkg::ADDR_TA_LO:  rd_val = cur.ta.cnt[7:0];
                    dtip_pkg::ADDR_TA_HI:  rd_val = cur.ta.cnt[15:8];
                    dtip_pkg::ADDR_TB_LO:  rd_val = cur.tb.cnt[7:0];
                    dtip_pkg::ADDR_TB_HI:  rd_val = cur.tb.cnt[15:8];
                    dtip_pkg::ADDR_SERIAL: rd_val = cur.serial;
                    dtip_pkg::ADDR_INT: begin
                        rd_val    = cur.flags;
                        nxt.flags = 8'h00;
                    end
                    dtip_pkg::ADDR_CTRL_A: rd_val = cur.ta.ctrl;
                    dtip_pkg::ADDR_CTRL_B: rd_val = cur.tb.ctrl;
                    default: rd_val = 8'h00;
                endcase
            end
            dtip_pkg::ACT_WRITE: begin
                case (s1_address_reg)
                    dtip_pkg::ADDR_PORT_A: nxt.port_a = s1_wdata_reg;
                    dtip_pkg::ADDR_PORT_B: nxt.port_b = s1_wdata_reg;
                    dtip_pkg::ADDR_DIR_A:  nxt.dir_a  = s1_wdata_reg;
                    dtip_pkg::ADDR_DIR_B:  nxt.dir_b  = s1_wdata_reg;
                    dtip_pkg::ADDR_TA_LO:  nxt.ta.reload[7:0] = s1_wdata_reg;
                    dtip_pkg::ADDR_TA_HI: begin
                        nxt.ta.reload[15:8] = s1_wdata_reg;
                        if (!cur.ta.ctrl[0]) nxt.ta.cnt = {s1_wdata_reg, cur.ta.reload[7:0]};
                    end
                    dtip_pkg::ADDR_TB_LO:  nxt.tb.reload[7:0] = s1_wdata_reg;
                    dtip_pkg::ADDR_TB_HI: begin
                        nxt.tb.reload[15:8] = s1_wdata_reg;
                        if (!cur.tb.ctrl[0]) nxt.tb.cnt = {s1_wdata_reg, cur.tb.reload[7:0]};
                    end
                    dtip_pkg::ADDR_SERIAL: begin
                        nxt.serial   = s1_wdata_reg;
                        nxt.flags[3] = 1'b1;
                        if (cur.enable[3]) nxt.flags[7] = 1'b1;
                    end
                    dtip_pkg::ADDR_INT: begin
                        if (s1_wdata_reg[7]) new_enable = cur.enable | s1_wdata_reg[6:0];
                        else                 new_enable = cur.enable & ~s1_wdata_reg[6:0];
                        nxt.enable = new_enable;
                        if ((cur.flags[4:0] & new_enable[4:0]) != 5'd0) nxt.flags[7] = 1'b1;
                    end
                    dtip_pkg::ADDR_CTRL_A: begin
                        nxt.ta.staged          = {1'b1, s1_wdata_reg};
                        nxt.count_source[0]    = !s1_wdata_reg[5];
                    end
                    dtip_pkg::ADDR_CTRL_B: begin
                        nxt.tb.staged          = {1'b1, s1_wdata_reg};
                        nxt.count_source[1]    = (s1_wdata_reg[6:5] == 2'b00);
                        nxt.count_source[2]    = (s1_wdata_reg[6:5] == 2'b10);
                    end
                    default: begin
                    end
                endcase
            end
            dtip_pkg::ACT_TICK: begin
                nxt.ta       = ta_next;
                nxt.tb       = tb_next;
                nxt.flags[0] = cur.flags[0] | ta_raise;
                nxt.flags[1] = cur.flags[1] | tb_raise;
                if ((cur.enable[0] && ta_raise) || (cur.enable[1] && tb_raise))
                    nxt.flags[7] = 1'b1;
            end
            default: begin
                nxt.flags[4:0] = cur.flags[4:0] | s1_src_reg;
                if ((cur.enable[4:0] & s1_src_reg) != 5'd0) nxt.flags[7] = 1'b1;
            end
        endcase
    end

    // state memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s1_idx_reg] <= nxt;
        end
        if (accept) begin
            mem_q_reg <= mem[in_idx];
        end
    end

    // payload of stage 1, write-back copy and output data
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ok_reg      <= in_ok;
            s1_idx_reg     <= in_idx;
            s1_unit_reg    <= s_unit;
            s1_action_reg  <= s_action;
            s1_address_reg <= s_address;
            s1_wdata_reg   <= s_write_data;
            s1_src_reg     <= s_source_bits;
            mem_ok_reg     <= written_reg[in_idx];
        end
        if (wr_en) begin
            wb_data_reg <= nxt;
        end
        if (advance && s1_valid_reg) begin
            m_read_data_reg <= s1_ok_reg ? rd_val : 8'h00;
            m_irq_reg       <= s1_ok_reg ? nxt.flags[7] : 1'b0;
        end
    end

    // control: pipe valids, forward flag, written marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
            written_reg  <= '0;
        end else begin
            if (advance) begin
                s1_valid_reg <= accept;
                m_valid_reg  <= s1_valid_reg;
            end
            if (accept) begin
                fwd_reg <= wr_en && (s1_idx_reg == in_idx);
            end
            if (wr_en) begin
                written_reg[s1_idx_reg] <= 1'b1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_read_data_reg;
    assign m_irq_pending = m_irq_reg;

endmodule

// ----- rtl/core/dtip_checker.sv -----
// Port-level checks for the dual timer and interrupt port block, and the bind
// that attaches them to the top level. Depends on dtip_pkg.
module dtip_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_action,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_irq_pending
);

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result present after reset");

    // a free output register never holds off the input
    assert property (@(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // anything but a bus read returns zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action != dtip_pkg::ACT_READ) ##1 m_ready
        |=> m_valid && m_read_data == 8'h00)
        else $error("non-read transfer returned data");

    // a held result does not change
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_irq_pending))
        else $error("stalled result changed");

endmodule

bind dual_timer_interrupt_port_block_top dtip_checker u_dtip_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking bench for dual_timer_interrupt_port_block_top: directed and random
// bus, tick and raise traffic checked against a built-in predictor of both units.
// Depends on dtip_pkg and the block's RTL only.
module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
    } port_result_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_action      = dtip_pkg::ACT_READ;
    logic       s_unit        = 1'b0;
    logic [3:0] s_address     = 4'd0;
    logic [7:0] s_write_data  = 8'd0;
    logic [4:0] s_source_bits = 5'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_read_data;
    logic       m_irq_pending;

    // predictor state, one entry per unit
    logic [7:0]       pred_port_a [2];
    logic [7:0]       pred_port_b [2];
    logic [7:0]       pred_dir_a  [2];
    logic [7:0]       pred_dir_b  [2];
    logic [7:0]       pred_serial [2];
    logic [7:0]       pred_flags  [2];
    logic [6:0]       pred_enable [2];
    dtip_pkg::timer_t pred_ta     [2];
    dtip_pkg::timer_t pred_tb     [2];
    logic [2:0]       pred_source [2];

    port_result_t predicted_q[$];
    int error_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int underflows     = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    dual_timer_interrupt_port_block_top #(.UNITS(2)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action), .s_unit(s_unit),
        .s_address(s_address), .s_write_data(s_write_data),
        .s_source_bits(s_source_bits),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data),
        .m_irq_pending(m_irq_pending)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic void raise_flags(input int u, input logic [7:0] bits);
        pred_flags[u] = pred_flags[u] | bits;
        if ((pred_enable[u] & bits[6:0]) != 7'd0) pred_flags[u][7] = 1'b1;
    endfunction

    // advance one timer by one tick; returns the underflow
    function automatic logic step_timer(input int u, inout dtip_pkg::timer_t t,
                                        input logic tick_in, input logic [7:0] flag);
        logic       forced;
        logic       under;
        logic       counting;
        logic       zero;
        logic [7:0] nv;
        forced   = 1'b0;
        under    = 1'b0;
        counting = 1'b0;
        case (t.phase)
            dtip_pkg::PH_WAIT_COUNT: t.phase = dtip_pkg::PH_COUNT;
            dtip_pkg::PH_LOAD_STOP: begin
                t.phase = dtip_pkg::PH_STOP;
                t.cnt   = t.reload;
            end
            dtip_pkg::PH_LOAD_COUNT: begin
                t.phase = dtip_pkg::PH_COUNT;
                t.cnt   = t.reload;
            end
            dtip_pkg::PH_LOAD_WAIT_COUNT: begin
                t.phase = dtip_pkg::PH_WAIT_COUNT;
                if (t.cnt == 16'd1) begin
                    forced   = 1'b1;
                    counting = 1'b1;
                end else begin
                    t.cnt = t.reload;
                end
            end
            dtip_pkg::PH_COUNT_STOP: begin
                t.phase  = dtip_pkg::PH_STOP;
                counting = 1'b1;
            end
            dtip_pkg::PH_COUNT: counting = 1'b1;
            default: ;
        endcase
        if (counting && (tick_in || forced)) begin
            zero = (t.cnt == 16'd0);
            if (!zero) begin
                t.cnt = t.cnt - 16'd1;
                zero  = (t.cnt == 16'd0);
            end
            if (zero || forced) begin
                if (t.phase != dtip_pkg::PH_STOP || forced) begin
                    t.cnt = t.reload;
                    raise_flags(u, flag);
                    if (t.ctrl[3]) begin
                        t.ctrl[0]   = 1'b0;
                        t.staged[0] = 1'b0;
                        t.phase     = dtip_pkg::PH_LOAD_STOP;
                    end else begin
                        t.phase = dtip_pkg::PH_LOAD_COUNT;
                    end
                end
                under = 1'b1;
            end
        end
        if (t.staged[8]) begin
            nv = t.staged[7:0];
            case (t.phase)
                dtip_pkg::PH_COUNT: begin
                    if (nv[0]) begin
                        if (nv[4]) t.phase = dtip_pkg::PH_LOAD_WAIT_COUNT;
                    end else begin
                        t.phase = nv[4] ? dtip_pkg::PH_LOAD_STOP : dtip_pkg::PH_COUNT_STOP;
                    end
                end
                dtip_pkg::PH_LOAD_COUNT, dtip_pkg::PH_WAIT_COUNT: begin
                    if (nv[0]) begin
                        if (nv[3]) begin
                            nv[0]   = 1'b0;
                            t.phase = dtip_pkg::PH_STOP;
                        end else if (nv[4]) begin
                            t.phase = dtip_pkg::PH_LOAD_WAIT_COUNT;
                        end
                    end else begin
                        t.phase = dtip_pkg::PH_STOP;
                    end
                end
                dtip_pkg::PH_LOAD_WAIT_COUNT, dtip_pkg::PH_COUNT_STOP: ;
                default: begin
                    if (nv[0]) begin
                        t.phase = nv[4] ? dtip_pkg::PH_LOAD_WAIT_COUNT
                                        : dtip_pkg::PH_WAIT_COUNT;
                    end else if (nv[4]) begin
                        t.phase = dtip_pkg::PH_LOAD_STOP;
                    end
                end
            endcase
            t.ctrl   = nv & 8'hef;
            t.staged = 9'd0;
        end
        return under;
    endfunction

    function automatic port_result_t predict_step(input logic [1:0] act, input int u,
                                                  input logic [3:0] addr,
                                                  input logic [7:0] wd,
                                                  input logic [4:0] src);
        port_result_t r;
        logic ua;
        logic ub;
        logic tb_in;
        r.read_data = 8'd0;
        case (act)
            dtip_pkg::ACT_READ: begin
                case (addr)
                    dtip_pkg::ADDR_PORT_A: begin
                        r.read_data = pred_port_a[u] | ~pred_dir_a[u];
                        if (u == 1) r.read_data = r.read_data & 8'h3f;
                    end
                    dtip_pkg::ADDR_PORT_B: r.read_data = pred_port_b[u] | ~pred_dir_b[u];
                    dtip_pkg::ADDR_DIR_A:  r.read_data = pred_dir_a[u];
                    dtip_pkg::ADDR_DIR_B:  r.read_data = pred_dir_b[u];
                    dtip_pkg::ADDR_TA_LO:  r.read_data = pred_ta[u].cnt[7:0];
                    dtip_pkg::ADDR_TA_HI:  r.read_data = pred_ta[u].cnt[15:8];
                    dtip_pkg::ADDR_TB_LO:  r.read_data = pred_tb[u].cnt[7:0];
                    dtip_pkg::ADDR_TB_HI:  r.read_data = pred_tb[u].cnt[15:8];
                    dtip_pkg::ADDR_SERIAL: r.read_data = pred_serial[u];
                    dtip_pkg::ADDR_INT: begin
                        r.read_data   = pred_flags[u];
                        pred_flags[u] = 8'd0;
                    end
                    dtip_pkg::ADDR_CTRL_A: r.read_data = pred_ta[u].ctrl;
                    dtip_pkg::ADDR_CTRL_B: r.read_data = pred_tb[u].ctrl;
                    default: ;
                endcase
            end
            dtip_pkg::ACT_WRITE: begin
                case (addr)
                    dtip_pkg::ADDR_PORT_A: pred_port_a[u] = wd;
                    dtip_pkg::ADDR_PORT_B: pred_port_b[u] = wd;
                    dtip_pkg::ADDR_DIR_A:  pred_dir_a[u]  = wd;
                    dtip_pkg::ADDR_DIR_B:  pred_dir_b[u]  = wd;
                    dtip_pkg::ADDR_TA_LO:  pred_ta[u].reload[7:0] = wd;
                    dtip_pkg::ADDR_TA_HI: begin
                        pred_ta[u].reload[15:8] = wd;
                        if (!pred_ta[u].ctrl[0]) pred_ta[u].cnt = pred_ta[u].reload;
                    end
                    dtip_pkg::ADDR_TB_LO:  pred_tb[u].reload[7:0] = wd;
                    dtip_pkg::ADDR_TB_HI: begin
                        pred_tb[u].reload[15:8] = wd;
                        if (!pred_tb[u].ctrl[0]) pred_tb[u].cnt = pred_tb[u].reload;
                    end
                    dtip_pkg::ADDR_SERIAL: begin
                        pred_serial[u] = wd;
                        raise_flags(u, 8'h08);
                    end
                    dtip_pkg::ADDR_INT: begin
                        if (wd[7]) pred_enable[u] = pred_enable[u] | wd[6:0];
                        else pred_enable[u] = pred_enable[u] & ~wd[6:0];
                        if ((pred_flags[u][4:0] & pred_enable[u][4:0]) != 5'd0)
                            pred_flags[u][7] = 1'b1;
                    end
                    dtip_pkg::ADDR_CTRL_A: begin
                        pred_ta[u].staged = {1'b1, wd};
                        pred_source[u][0] = (wd[5] == 1'b0);
                    end
                    dtip_pkg::ADDR_CTRL_B: begin
                        pred_tb[u].staged = {1'b1, wd};
                        pred_source[u][1] = (wd[6:5] == 2'b00);
                        pred_source[u][2] = (wd[6:5] == 2'b10);
                    end
                    default: ;
                endcase
            end
            dtip_pkg::ACT_TICK: begin
                ua    = step_timer(u, pred_ta[u], pred_source[u][0], 8'h01);
                tb_in = pred_source[u][1] || (pred_source[u][2] && ua);
                ub    = step_timer(u, pred_tb[u], tb_in, 8'h02);
                underflows += int'(ua) + int'(ub);
            end
            default: raise_flags(u, {3'b000, src});
        endcase
        r.irq = pred_flags[u][7];
        return r;
    endfunction

    // ---------------------------------------------------------------- sender

    // offer one item, idling first at the current sender rate; returns at the
    // edge of its transfer, with the prediction already queued
    task automatic send_item(input logic [1:0] act, input logic u, input logic [3:0] addr,
                             input logic [7:0] wd, input logic [4:0] src);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_unit        <= u;
        s_address     <= addr;
        s_write_data  <= wd;
        s_source_bits <= src;
        do @(posedge aclk); while (!s_ready);
        predicted_q.push_back(predict_step(act, int'(u), addr, wd, src));
        items_sent++;
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold the sender until every predicted result has been taken
    task automatic wait_drained();
        go_idle();
        while (predicted_q.size() != 0) @(posedge aclk);
    endtask

    // one random item, biased so that timers load small values and underflow often
    task automatic send_random_item();
        logic [1:0] act;
        logic [3:0] addr;
        logic [7:0] wd;
        int         pick;
        pick = $urandom_range(99);
        addr = 4'($urandom_range(15));
        wd   = 8'($urandom_range(255));
        if (pick < 45) begin
            act = dtip_pkg::ACT_TICK;
        end else if (pick < 70) begin
            act = dtip_pkg::ACT_WRITE;
            case ($urandom_range(5))
                0: addr = ($urandom_range(1)) ? dtip_pkg::ADDR_TA_LO : dtip_pkg::ADDR_TB_LO;
                1: begin
                    addr = ($urandom_range(1)) ? dtip_pkg::ADDR_TA_HI : dtip_pkg::ADDR_TB_HI;
                    if ($urandom_range(7) != 0) wd = 8'd0;
                end
                2: addr = ($urandom_range(1)) ? dtip_pkg::ADDR_CTRL_A : dtip_pkg::ADDR_CTRL_B;
                3: addr = dtip_pkg::ADDR_INT;
                default: ;
            endcase
            if ((addr == dtip_pkg::ADDR_TA_LO || addr == dtip_pkg::ADDR_TB_LO)
                && $urandom_range(3) != 0)
                wd = 8'($urandom_range(6));
        end else if (pick < 92) begin
            act = dtip_pkg::ACT_READ;
        end else begin
            act = dtip_pkg::ACT_RAISE;
        end
        send_item(act, 1'($urandom_range(1)), addr, wd, 5'($urandom_range(31)));
    endtask

    // ---------------------------------------------------------------- receiver

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // check each result transfer and drive m_ready for the next edge
    always @(posedge aclk) begin
        port_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_q.size() == 0) begin
                report_mismatch("unexpected result", int'(m_read_data), 0);
            end else begin
                want = predicted_q.pop_front();
                if (m_read_data !== want.read_data)
                    report_mismatch("read_data", int'(m_read_data), int'(want.read_data));
                if (m_irq_pending !== want.irq)
                    report_mismatch("irq_pending", int'(m_irq_pending), int'(want.irq));
            end
            results_seen++;
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // stop the run when no transfer happens on either side for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic reset_predictor();
        for (int u = 0; u < 2; u++) begin
            pred_port_a[u] = 8'd0;
            pred_port_b[u] = 8'd0;
            pred_dir_a[u]  = 8'd0;
            pred_dir_b[u]  = 8'd0;
            pred_serial[u] = 8'd0;
            pred_flags[u]  = 8'd0;
            pred_enable[u] = 7'd0;
            pred_ta[u]     = dtip_pkg::TIMER_RESET_C;
            pred_tb[u]     = dtip_pkg::TIMER_RESET_C;
            pred_source[u] = 3'd0;
        end
    endtask

    // read back reset values, including the unmodelled clock registers
    task automatic test_reset_values();
        send_item(dtip_pkg::ACT_READ, 1'b1, dtip_pkg::ADDR_PORT_A, 8'h00, 5'h00);
        send_item(dtip_pkg::ACT_READ, 1'b0, dtip_pkg::ADDR_TA_HI, 8'h00, 5'h00);
        send_item(dtip_pkg::ACT_READ, 1'b0, 4'd9, 8'h00, 5'h00);
        send_item(dtip_pkg::ACT_WRITE, 1'b0, 4'd10, 8'hff, 5'h00);
    endtask

    // port latches and direction masks at their extremes
    task automatic test_ports();
        send_item(dtip_pkg::ACT_WRITE, 1'b1, dtip_pkg::ADDR_PORT_A, 8'hff, 5'h00);
        send_item(dtip_pkg::ACT_WRITE, 1'b1, dtip_pkg::ADDR_DIR_A, 8'h0f, 5'h00);
        send_item(dtip_pkg::ACT_READ, 1'b1, dtip_pkg::ADDR_PORT_A, 8'h00, 5'h00);
        send_item(dtip_pkg::ACT_WRITE, 1'b0, dtip_pkg::ADDR_DIR_B, 8'hff, 5'h00);
        send_item(dtip_pkg::ACT_READ, 1'b0, dtip_pkg::ADDR_PORT_B, 8'h00, 5'h00);
    endtask

    // force-load a one-shot timer A and let it run out, timer B chained to it
    task automatic test_timers();
        send_item(dtip_pkg::ACT_WRITE, 1'b0, dtip_pkg::ADDR_TA_LO, 8'h02, 5'h00);
        send_item(dtip_pkg::ACT_WRITE, 1'b0, dtip_pkg::ADDR_TA_HI, 8'h00, 5'h00);
        send_item(dtip_pkg::ACT_WRITE, 1'b0, dtip_pkg::ADDR_CTRL_B, 8'h51, 5'h00);
        send_item(dtip_pkg::ACT_WRITE, 1'b0, dtip_pkg::ADDR_CTRL_A, 8'h19, 5'h00);
        repeat (6) send_item(dtip_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 5'h00);
        send_item(dtip_pkg::ACT_READ, 1'b0, dtip_pkg::ADDR_CTRL_A, 8'h00, 5'h00);
        send_item(dtip_pkg::ACT_READ, 1'b0, dtip_pkg::ADDR_TB_LO, 8'h00, 5'h00);
    endtask

    // enable mask, serial flag, raised sources and the clearing read
    task automatic test_interrupts();
        send_item(dtip_pkg::ACT_WRITE, 1'b1, dtip_pkg::ADDR_INT, 8'hff, 5'h00);
        send_item(dtip_pkg::ACT_RAISE, 1'b1, 4'd0, 8'h00, 5'h1f);
        send_item(dtip_pkg::ACT_WRITE, 1'b1, dtip_pkg::ADDR_SERIAL, 8'ha5, 5'h00);
        send_item(dtip_pkg::ACT_READ, 1'b1, dtip_pkg::ADDR_INT, 8'h00, 5'h00);
        send_item(dtip_pkg::ACT_READ, 1'b1, dtip_pkg::ADDR_INT, 8'h00, 5'h00);
        send_item(dtip_pkg::ACT_WRITE, 1'b1, dtip_pkg::ADDR_INT, 8'h7f, 5'h00);
    endtask

    task automatic test_random(input int s_pct, input int r_pct, input int count);
        wait_drained();
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) send_random_item();
    endtask

    // stall the result side while items keep coming, so the input backs up
    task automatic test_backpressure();
        wait_drained();
        send_idle_pct = 0;
        hold_request  = 300;
        repeat (60) send_random_item();
        wait_drained();
    endtask

    initial begin
        reset_predictor();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_ports();
        test_timers();
        test_interrupts();
        test_random(14, 87, 580);
        test_random(87, 14, 580);
        test_random(0, 0, 520);
        test_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d items (reads, writes, ticks, raises on both units), %0d results,",
                 items_sent, results_seen);
        $display("%0d timer underflows, three idling mixes and one long result stall",
                 underflows);
        if (error_count == 0 && predicted_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results outstanding", error_count,
                     predicted_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
